// File: hw/rtl/framed_packet_checker_assert.svh
// Assertion macros shared by the framed packet checker RTL.
`ifndef FRAMED_PACKET_CHECKER_ASSERT_SVH
`define FRAMED_PACKET_CHECKER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high.
`define FPC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, disabled while reset is high.
`define FPC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define FPC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define FPC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// File: hw/rtl/fpc_pkg.sv
// Shared types and constants of the framed packet checker.
package fpc_pkg;

   localparam logic [8:0] POS_MAX        = 9'd511;
   localparam logic [8:0] HEADER_BYTES   = 9'd4;
   localparam logic [8:0] FRAME_OVERHEAD = 9'd6;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_SHORT = 2'd1,
      ST_PROTO = 2'd2
   } status_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] command;
      logic [7:0]  payload_length;
   } verdict_type;

endpackage

// File: hw/rtl/fpc_req_if.sv
// Input byte channel of the framed packet checker.
interface fpc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       end_of_buffer;

   modport source (output valid, output rx_byte, output end_of_buffer, input ready);
   modport sink   (input valid, input rx_byte, input end_of_buffer, output ready);
endinterface

// File: hw/rtl/fpc_rsp_if.sv
// Verdict channel of the framed packet checker.
interface fpc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] command;
   logic [7:0]  payload_length;

   modport source (output valid, output status, output command, output payload_length,
                   input ready);
   modport sink   (input valid, input status, input command, input payload_length,
                   output ready);
endinterface

// File: hw/rtl/fpc_frame_tracker.sv
// Frame state tracker: per-byte header capture, running sums and verdict logic.
module fpc_frame_tracker
   import fpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic [7:0]  magic,
   input  logic [7:0]  rx_byte,
   input  logic        end_of_buffer,
   output verdict_type verdict
);

   logic [8:0]  pos_ff, pos_in;
   logic [15:0] cmd_ff, cmd_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  sum_a_ff, sum_a_in;
   logic [7:0]  sum_b_ff, sum_b_in;
   logic        magic_bad_ff, magic_bad_in;
   logic        first_ok_ff, first_ok_in;
   logic        check_ok_ff, check_ok_in;
   logic [8:0]  ck1;
   logic [8:0]  frame_len;
   logic [7:0]  add_a;

   always_comb begin
      pos_in       = pos_ff;
      cmd_in       = cmd_ff;
      len_in       = len_ff;
      sum_a_in     = sum_a_ff;
      sum_b_in     = sum_b_ff;
      magic_bad_in = magic_bad_ff;
      first_ok_in  = first_ok_ff;
      check_ok_in  = check_ok_ff;
      ck1          = HEADER_BYTES + {1'b0, len_ff};
      add_a        = sum_a_ff + rx_byte;

      if (pos_ff == 9'd0) begin
         magic_bad_in = (rx_byte != magic);
      end else if (pos_ff == 9'd1) begin
         cmd_in = {rx_byte, 8'h00};
      end else if (pos_ff == 9'd2) begin
         cmd_in = {cmd_ff[15:8], rx_byte};
      end else if (pos_ff == 9'd3) begin
         len_in = rx_byte;
      end else if (pos_ff < ck1) begin
         sum_a_in = add_a;
         sum_b_in = sum_b_ff + add_a;
      end else if (pos_ff == ck1) begin
         first_ok_in = (rx_byte == sum_a_ff);
      end else if (pos_ff == ck1 + 9'd1) begin
         check_ok_in = first_ok_ff && (rx_byte == sum_b_ff);
      end

      if (pos_ff < POS_MAX) begin
         pos_in = pos_ff + 9'd1;
      end

      // Verdict on the state as it stands after this byte.
      frame_len = {1'b0, len_in} + FRAME_OVERHEAD;
      verdict   = '{status: ST_OK, command: 16'h0000, payload_length: 8'h00};
      if (pos_in < FRAME_OVERHEAD) begin
         verdict.status = ST_SHORT;
      end else if (magic_bad_in) begin
         verdict.status = ST_PROTO;
      end else begin
         verdict.command        = cmd_in;
         verdict.payload_length = len_in;
         if (pos_in < frame_len) begin
            verdict.status = ST_SHORT;
         end else if (check_ok_in) begin
            verdict.status = ST_OK;
         end else begin
            verdict.status = ST_PROTO;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && end_of_buffer)) begin
         pos_ff       <= '0;
         cmd_ff       <= '0;
         len_ff       <= '0;
         sum_a_ff     <= '0;
         sum_b_ff     <= '0;
         magic_bad_ff <= 1'b0;
         first_ok_ff  <= 1'b0;
         check_ok_ff  <= 1'b0;
      end else if (step) begin
         pos_ff       <= pos_in;
         cmd_ff       <= cmd_in;
         len_ff       <= len_in;
         sum_a_ff     <= sum_a_in;
         sum_b_ff     <= sum_b_in;
         magic_bad_ff <= magic_bad_in;
         first_ok_ff  <= first_ok_in;
         check_ok_ff  <= check_ok_in;
      end
   end

endmodule

// File: hw/rtl/framed_packet_checker.sv
// Top level of the framed packet checker: input register, tracker and verdict register.
//
//   Channel   Direction  Contents
//   req_ch    in         rx_byte, end_of_buffer (one buffer byte per transfer)
//   rsp_ch    out        status, command, payload_length (one per buffer)
//   csr_*     in         magic byte, written with csr_write_enable
//
// A new byte is taken every cycle unless a final byte is held behind a waiting verdict.
// A transferred byte passes through the input register, then the tracker logic
// feeding the verdict register.
// Reset is synchronous and active high; it clears the magic register, the frame
// state and both valid flags.
// A stalled verdict holds only bytes that end a buffer; other bytes keep flowing.
`include "framed_packet_checker_assert.svh"

module framed_packet_checker
   import fpc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data,
   fpc_req_if.sink    req_ch,
   fpc_rsp_if.source  rsp_ch
);

   logic [7:0]  magic_ff;
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;
   logic        rsp_valid_ff;
   verdict_type rsp_data_ff;
   verdict_type verdict;
   logic        advance;

   // A byte in the input register advances unless it ends a buffer and the
   // verdict register still holds a result that is not being taken.
   assign advance = in_valid_ff &&
                    (!in_last_ff || !rsp_valid_ff || rsp_ch.ready);

   // The input register refills whenever it is empty or its byte moves on.
   assign req_ch.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff <= '0;
      end else if (csr_write_enable) begin
         magic_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_byte_ff <= req_ch.rx_byte;
         in_last_ff <= req_ch.end_of_buffer;
      end
   end

   fpc_frame_tracker u_tracker (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .magic         (magic_ff),
      .rx_byte       (in_byte_ff),
      .end_of_buffer (in_last_ff),
      .verdict       (verdict)
   );

   // The verdict register loads on a buffer's final byte and empties on a transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_last_ff) begin
         rsp_data_ff <= verdict;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_data_ff.status;
   assign rsp_ch.command        = rsp_data_ff.command;
   assign rsp_ch.payload_length = rsp_data_ff.payload_length;

   // A final byte that advances always leaves a verdict waiting.
   `FPC_ASSERT_NXT(a_last_gives_verdict, clock, reset, advance && in_last_ff, rsp_valid_ff, "final byte produced no verdict")

   // A held byte stays in the input register unchanged.
   `FPC_ASSERT_NXT(a_held_byte_stable, clock, reset, in_valid_ff && !advance, in_valid_ff && $stable(in_byte_ff) && $stable(in_last_ff), "held input byte changed")

   // Only a final byte can be held, and only behind a waiting verdict.
   `FPC_ASSERT_IMP(a_hold_cause, clock, reset, in_valid_ff && !advance, in_last_ff && rsp_valid_ff && !rsp_ch.ready, "input held without a blocked verdict")

endmodule
